### hdl/snmp_pkg.sv
// ---------------------------------------------------------------------------
// snmp_pkg: shared types and helpers for the soft neighbor max pass unit
// Pixel and window-job types, fixed point constants and per-channel math.
// ---------------------------------------------------------------------------
`default_nettype none

package snmp_pkg;

   // fixed point format of every channel
   localparam int unsigned FRAC_BITS = 15;
   localparam int unsigned CHAN_W    = 16;
   localparam int unsigned BRIGHT_W  = CHAN_W + 2;
   localparam int unsigned PROD_W    = 2 * CHAN_W - 2;
   localparam logic [31:0] ONE_VAL   = 32'(1) << FRAC_BITS;

   // pending window jobs between the window and the compare stage
   localparam int unsigned QUEUE_DEPTH = 3;
   localparam int unsigned COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef logic [CHAN_W-1:0]   chan_type;
   typedef logic [BRIGHT_W-1:0] bright_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
   } pixel_type;

   typedef struct packed {
      pixel_type lft;
      pixel_type ctr;
      pixel_type rgt;
      logic      done;
   } job_type;

   typedef enum logic {
      MODE_RGB   = 1'b0,
      MODE_ALPHA = 1'b1
   } mode_type;

   // clip a channel to 1.0; no clipping when 1.0 is beyond 16 bits
   function automatic chan_type saturate(input chan_type c);
      if (32'(c) > ONE_VAL) begin
         return ONE_VAL[CHAN_W-1:0];
      end
      return c;
   endfunction

   function automatic bright_type bright(input pixel_type p, input mode_type m);
      if (m == MODE_ALPHA) begin
         return BRIGHT_W'(p.alpha);
      end
      return BRIGHT_W'(p.red) + BRIGHT_W'(p.green) + BRIGHT_W'(p.blue);
   endfunction

   // c + n/4 - c*(n/4), clamped to n
   function automatic chan_type blend(input chan_type c, input chan_type n);
      logic [CHAN_W-3:0] q;
      logic [PROD_W-1:0] prod;
      logic [CHAN_W:0]   t;
      q    = n[CHAN_W-1:2];
      prod = PROD_W'(c) * PROD_W'(q);
      prod = prod >> FRAC_BITS;
      t    = (CHAN_W+1)'(c) + (CHAN_W+1)'(q) - prod[CHAN_W:0];
      if (t > {1'b0, n}) begin
         t = {1'b0, n};
      end
      return t[CHAN_W-1:0];
   endfunction

endpackage

`default_nettype wire

### hdl/snmp_window.sv
// ---------------------------------------------------------------------------
// snmp_window: three pixel window and job queue
// Saturates incoming pixels, tracks the line window and queues up to three
// left/center/right jobs for the compare stage.
// ---------------------------------------------------------------------------
`default_nettype none

module snmp_window (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  snmp_pkg::pixel_type  in_pixel,
   input  wire                  in_last,
   output logic                 head_valid,
   output snmp_pkg::job_type    head_job,
   input  wire                  head_pop
);
   import snmp_pkg::*;

   localparam logic [1:0] FILL_EMPTY  = 2'd0;
   localparam logic [1:0] FILL_CENTER = 2'd1;
   localparam logic [1:0] FILL_FULL   = 2'd2;

   pixel_type          left_ff, left_in;
   pixel_type          center_ff, center_in;
   logic [1:0]         fill_ff, fill_in;
   job_type            job_ff [QUEUE_DEPTH];
   job_type            job_in [QUEUE_DEPTH];
   job_type            job_shift [QUEUE_DEPTH];
   logic [COUNT_W-1:0] count_ff, count_in;

   pixel_type          px;
   pixel_type          lft;
   logic               accept;
   logic [1:0]         push_count;
   job_type            push0, push1;
   logic [COUNT_W-1:0] base;

   always_comb begin
      px.red   = saturate(in_pixel.red);
      px.green = saturate(in_pixel.green);
      px.blue  = saturate(in_pixel.blue);
      px.alpha = saturate(in_pixel.alpha);

      in_ready   = (count_ff < COUNT_W'(2));
      accept     = in_valid && in_ready;
      head_valid = (count_ff != '0);
      head_job   = job_ff[0];

      left_in    = left_ff;
      center_in  = center_ff;
      fill_in    = fill_ff;
      push_count = 2'd0;
      push0      = '0;
      push1      = '0;
      lft        = (fill_ff == FILL_CENTER) ? center_ff : left_ff;

      if (accept) begin
         if (fill_ff == FILL_EMPTY) begin
            if (in_last) begin
               // single-pixel line
               push0      = '{lft: px, ctr: px, rgt: px, done: 1'b1};
               push_count = 2'd1;
            end else begin
               center_in = px;
               fill_in   = FILL_CENTER;
            end
         end else begin
            push0      = '{lft: lft, ctr: center_ff, rgt: px, done: 1'b0};
            push_count = 2'd1;
            if (in_last) begin
               // flush: last pixel is its own right neighbor
               push1      = '{lft: center_ff, ctr: px, rgt: px, done: 1'b1};
               push_count = 2'd2;
               fill_in    = FILL_EMPTY;
            end else begin
               left_in   = center_ff;
               center_in = px;
               fill_in   = FILL_FULL;
            end
         end
      end

      // drop head on pop, then append new jobs behind the survivors
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         job_shift[i] = head_pop ? job_ff[i+1] : job_ff[i];
      end
      job_shift[QUEUE_DEPTH-1] = job_ff[QUEUE_DEPTH-1];

      base = count_ff - COUNT_W'(head_pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         job_in[i] = job_shift[i];
         if (push_count != 2'd0 && COUNT_W'(i) == base) begin
            job_in[i] = push0;
         end else if (push_count == 2'd2 && COUNT_W'(i) == base + COUNT_W'(1)) begin
            job_in[i] = push1;
         end
      end
      count_in = base + COUNT_W'(push_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= FILL_EMPTY;
         count_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
      left_ff   <= left_in;
      center_ff <= center_in;
      job_ff    <= job_in;
   end

endmodule

`default_nettype wire

### hdl/soft_neighbor_max_pass_unit.sv
// ---------------------------------------------------------------------------
// soft_neighbor_max_pass_unit: one-dimensional soft dilation of RGBA pixels
// Streams Q1.15 pixels along a line and pulls each darker pixel toward its
// brighter neighbor.
// ---------------------------------------------------------------------------
// Pixels enter on the req_ channel, at most one transfer per clock, and results
// leave on the rsp_ channel in the same order. A pixel's result appears once its
// right neighbor has arrived, so each pixel without req_line_last, other than
// the first of a line, gives the result of the previous pixel; the first
// pixel of a line gives none; a pixel with req_line_last gives two results
// (one for a single-pixel line), the second carrying rsp_line_done. Steady
// throughput is one pixel per clock while rsp_ready is high; each line end adds
// one extra result, absorbed by a three-entry job queue, which holds req_ready
// low only while two or more jobs are waiting. A transfer's first result
// passes the window/queue, neighbor compare and blend/output registers in
// turn. csr_write_data selects the mode: 0 compares R+G+B and blends the color
// channels, 1 compares and blends alpha only. Write it only while idle.
`default_nettype none

module soft_neighbor_max_pass_unit (
   input  wire                     clock,
   input  wire                     reset,
   // configuration
   input  wire                     csr_write_enable,
   input  wire                     csr_write_data,
   // input pixel channel
   input  wire                     req_valid,
   output logic                    req_ready,
   input  snmp_pkg::chan_type      req_red_in,
   input  snmp_pkg::chan_type      req_green_in,
   input  snmp_pkg::chan_type      req_blue_in,
   input  snmp_pkg::chan_type      req_alpha_in,
   input  wire                     req_line_last,
   // result pixel channel
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output snmp_pkg::chan_type      rsp_red_out,
   output snmp_pkg::chan_type      rsp_green_out,
   output snmp_pkg::chan_type      rsp_blue_out,
   output snmp_pkg::chan_type      rsp_alpha_out,
   output logic                    rsp_line_done
);
   import snmp_pkg::*;

   // mode register
   mode_type   mode_ff, mode_in;

   // window / queue head
   pixel_type  in_pixel;
   logic       head_valid;
   job_type    head_job;
   logic       head_pop;

   // compare stage
   logic       s1_valid_ff, s1_valid_in;
   pixel_type  s1_nb_ff, s1_nb_in;
   pixel_type  s1_ctr_ff, s1_ctr_in;
   logic       s1_apply_ff, s1_apply_in;
   logic       s1_done_ff, s1_done_in;
   logic       s1_ready;

   // blend / output stage
   logic       out_valid_ff, out_valid_in;
   pixel_type  out_pixel_ff, out_pixel_in;
   logic       out_done_ff, out_done_in;
   logic       out_ready;
   logic       s1_move;

   bright_type b_lft, b_rgt, b_ctr, b_nb;
   logic       pick_right;

   assign in_pixel = '{red: req_red_in, green: req_green_in,
                       blue: req_blue_in, alpha: req_alpha_in};

   snmp_window u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_pixel   (in_pixel),
      .in_last    (req_line_last),
      .head_valid (head_valid),
      .head_job   (head_job),
      .head_pop   (head_pop)
   );

   // config write, no handshake
   always_comb begin
      mode_in = csr_write_enable ? mode_type'(csr_write_data) : mode_ff;
   end

   // stage ready chain, driven from the output side
   assign out_ready = !out_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign head_pop  = head_valid && s1_ready;
   assign s1_move   = s1_valid_ff && out_ready;

   // neighbor pick: right only when strictly brighter, ties go left
   always_comb begin
      b_lft      = bright(head_job.lft, mode_ff);
      b_rgt      = bright(head_job.rgt, mode_ff);
      b_ctr      = bright(head_job.ctr, mode_ff);
      pick_right = (b_lft < b_rgt);
      b_nb       = pick_right ? b_rgt : b_lft;

      s1_valid_in = s1_ready ? head_valid : s1_valid_ff;
      s1_nb_in    = s1_nb_ff;
      s1_ctr_in   = s1_ctr_ff;
      s1_apply_in = s1_apply_ff;
      s1_done_in  = s1_done_ff;
      if (head_pop) begin
         s1_nb_in    = pick_right ? head_job.rgt : head_job.lft;
         s1_ctr_in   = head_job.ctr;
         s1_apply_in = (b_ctr < b_nb);
         s1_done_in  = head_job.done;
      end
   end

   // blend darker center toward the chosen neighbor
   always_comb begin
      out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_done_in  = out_done_ff;
      if (s1_move) begin
         out_pixel_in = s1_ctr_ff;
         out_done_in  = s1_done_ff;
         if (s1_apply_ff) begin
            if (mode_ff == MODE_ALPHA) begin
               out_pixel_in.alpha = blend(s1_ctr_ff.alpha, s1_nb_ff.alpha);
            end else begin
               out_pixel_in.red   = blend(s1_ctr_ff.red, s1_nb_ff.red);
               out_pixel_in.green = blend(s1_ctr_ff.green, s1_nb_ff.green);
               out_pixel_in.blue  = blend(s1_ctr_ff.blue, s1_nb_ff.blue);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RGB;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_nb_ff     <= s1_nb_in;
      s1_ctr_ff    <= s1_ctr_in;
      s1_apply_ff  <= s1_apply_in;
      s1_done_ff   <= s1_done_in;
      out_pixel_ff <= out_pixel_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = out_pixel_ff.red;
   assign rsp_green_out = out_pixel_ff.green;
   assign rsp_blue_out  = out_pixel_ff.blue;
   assign rsp_alpha_out = out_pixel_ff.alpha;
   assign rsp_line_done = out_done_ff;

endmodule

`default_nettype wire
